@@ rtl/core/aesx_pkg.sv @@
// Package for the extended-key AES core: S-box tables, GF(2^8) helpers,
// key-length decode, function codes and command/status types. No dependencies.
`default_nettype none
package aesx_pkg;

  localparam int MaxRoundsDefault = 22;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_ENC  = 2'd1;
  localparam logic [1:0] FUNC_DEC  = 2'd2;

  localparam logic [7:0] RCON_INIT = 8'h01;

  typedef struct packed {
    logic load_key;     // write key word
    logic blk_cap;      // capture input block
    logic exp_start;    // clear expansion buffer from cipher key
    logic exp_step;     // generate one 4-byte key word
    logic blk_load;     // load block and add first round key
    logic rnd_step;     // one cipher round
    logic rnd_last;     // last round (no mix columns)
    logic dec;          // decrypt direction
  } aesx_cmd_t;

  typedef struct packed {
    logic exp_done;
    logic rnd_done;     // next round is the last
  } aesx_sts_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,
      8'hfe,8'hd7,8'hab,8'h76,8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,
      8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,
      8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,8'h04,8'hc7,8'h23,
      8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,
      8'he3,8'h2f,8'h84,8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,
      8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,
      8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,8'h51,8'ha3,8'h40,8'h8f,
      8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,8'hcd,
      8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,
      8'h19,8'h73,8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,
      8'h14,8'hde,8'h5e,8'h0b,8'hdb,8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
      8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,8'he7,8'hc8,8'h37,8'h6d,8'h8d,
      8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,8'hba,8'h78,
      8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,
      8'h8a,8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,
      8'h86,8'hc1,8'h1d,8'h9e,8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,
      8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,
      8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,
      8'h81,8'hf3,8'hd7,8'hfb,8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,
      8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,
      8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,8'h08,8'h2e,8'ha1,
      8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,
      8'h65,8'hb6,8'h92,8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,
      8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,
      8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,8'hd0,8'h2c,8'h1e,8'h8f,
      8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,8'h3a,
      8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,
      8'he6,8'h73,8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,
      8'he8,8'h1c,8'h75,8'hdf,8'h6e,8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,
      8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,8'hfc,8'h56,8'h3e,8'h4b,8'hc6,
      8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,8'h1f,8'hdd,
      8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,
      8'h5f,8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,
      8'h93,8'hc9,8'h9c,8'hef,8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,
      8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,
      8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // 2 and 3 multiples for forward mix; 9, 11, 13, 14 multiples for inverse mix
  function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] m3 [4];
    logic [31:0] r;
    for (int k = 0; k < 4; k++) begin
      a[k] = c[31-8*k -: 8];
      x2[k] = xt(a[k]);
      x4[k] = xt(x2[k]);
      x8[k] = xt(x4[k]);
      m3[k] = x2[k] ^ a[k];
      m9[k] = x8[k] ^ a[k];
      mb[k] = x8[k] ^ x2[k] ^ a[k];
      md[k] = x8[k] ^ x4[k] ^ a[k];
      me[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    if (!inv) begin
      r = {x2[0] ^ m3[1] ^ a[2] ^ a[3], a[0] ^ x2[1] ^ m3[2] ^ a[3],
           a[0] ^ a[1] ^ x2[2] ^ m3[3], m3[0] ^ a[1] ^ a[2] ^ x2[3]};
    end else begin
      r = {me[0] ^ mb[1] ^ md[2] ^ m9[3], m9[0] ^ me[1] ^ mb[2] ^ md[3],
           md[0] ^ m9[1] ^ me[2] ^ mb[3], mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    end
    return r;
  endfunction

  function automatic logic [3:0] shift_src(input logic [3:0] i);
    logic [3:0] t [16];
    t = '{4'd0,4'd5,4'd10,4'd15,4'd4,4'd9,4'd14,4'd3,
          4'd8,4'd13,4'd2,4'd7,4'd12,4'd1,4'd6,4'd11};
    return t[i];
  endfunction

  function automatic logic [3:0] inv_shift_src(input logic [3:0] i);
    logic [3:0] t [16];
    t = '{4'd0,4'd13,4'd10,4'd7,4'd4,4'd1,4'd14,4'd11,
          4'd8,4'd5,4'd2,4'd15,4'd12,4'd9,4'd6,4'd3};
    return t[i];
  endfunction

  // key length in 4-byte words
  function automatic logic [4:0] key_words(input logic [2:0] ks);
    case (ks)
      3'd0: return 5'd4;
      3'd1: return 5'd6;
      3'd2: return 5'd8;
      3'd3: return 5'd12;
      default: return 5'd16;
    endcase
  endfunction

  function automatic logic [4:0] key_rounds(input logic [2:0] ks);
    case (ks)
      3'd0: return 5'd10;
      3'd1: return 5'd12;
      3'd2: return 5'd14;
      3'd3: return 5'd18;
      default: return 5'd22;
    endcase
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/aesx_ctrl.sv @@
// Controller for the extended-key AES core: sequences key expansion and rounds.
// Depends on aesx_pkg.
`default_nettype none
module aesx_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [1:0]      func,
  input  wire logic            cfg_we,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output aesx_pkg::aesx_cmd_t  cmd,
  input  aesx_pkg::aesx_sts_t  sts
);
  import aesx_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CLR   = 3'd1;
  localparam logic [2:0] S_EXP   = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_RND   = 3'd4;
  localparam logic [2:0] S_LAST  = 3'd5;
  localparam logic [2:0] S_KEY   = 3'd6;

  logic [2:0] state, state_next;
  logic       keys_ok, keys_ok_next;
  logic       dec, dec_next;
  logic       out_valid_next;

  wire accept = in_valid && !in_stall;

  always_comb begin
    state_next     = state;
    keys_ok_next   = keys_ok;
    dec_next       = dec;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.dec        = dec;
    in_stall       = (state != S_IDLE) || out_valid;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (func)
            FUNC_LOAD: begin
              cmd.load_key = 1'b1;
              keys_ok_next = 1'b0;
            end
            FUNC_ENC, FUNC_DEC: begin
              dec_next   = (func == FUNC_DEC);
              state_next = keys_ok ? S_LOAD : S_CLR;
              cmd.blk_cap = 1'b1;
              // new direction already selects the first round key fetch
              cmd.dec     = (func == FUNC_DEC);
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        cmd.exp_start = 1'b1;
        state_next = S_EXP;
      end
      S_EXP: begin
        cmd.exp_step = 1'b1;
        if (sts.exp_done) begin
          keys_ok_next = 1'b1;
          state_next   = S_KEY;
        end
      end
      // last round key lands at the end of expansion; fetch it in S_KEY
      S_KEY: begin
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.blk_load = 1'b1;
        state_next = S_RND;
      end
      S_RND: begin
        cmd.rnd_step = 1'b1;
        if (sts.rnd_done) state_next = S_LAST;
      end
      S_LAST: begin
        cmd.rnd_step   = 1'b1;
        cmd.rnd_last   = 1'b1;
        out_valid_next = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (cfg_we) keys_ok_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      keys_ok   <= 1'b0;
      dec       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      keys_ok   <= keys_ok_next;
      dec       <= dec_next;
      out_valid <= out_valid_next;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/aesx_dp.sv @@
// Datapath of the extended-key AES core: cipher key, key schedule, round key
// memory and the shared round unit. Depends on aesx_pkg.
`default_nettype none
module aesx_dp #(
  parameter int MAX_ROUNDS = aesx_pkg::MaxRoundsDefault
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  aesx_pkg::aesx_cmd_t  cmd,
  output aesx_pkg::aesx_sts_t  sts,
  input  wire logic [2:0]      key_size_reg,
  input  wire logic [2:0]      key_index,
  input  wire logic [63:0]     key_word,
  input  wire logic [63:0]     block_hi,
  input  wire logic [63:0]     block_lo,
  output logic [63:0]          result_hi,
  output logic [63:0]          result_lo
);
  import aesx_pkg::*;

  localparam int Nrk   = MAX_ROUNDS + 1;
  localparam int RkW   = $clog2(Nrk);
  localparam int Nw    = 4 * Nrk;        // key words to generate
  localparam int WW    = $clog2(Nw + 1);

  logic [63:0]  cipher_key [8];
  logic [127:0] rk_mem [Nrk];
  logic [RkW-1:0] nr;

  // expansion: 16-word sliding window of previous key words
  logic [31:0]  win [16];
  logic [WW-1:0] widx;
  logic [4:0]   off;
  logic [7:0]   rcon;
  logic [95:0]  rk_part;

  logic [4:0]  kw, rounds;
  logic [4:0]  rounds_cap;
  assign kw     = key_words(key_size_reg);
  assign rounds = key_rounds(key_size_reg);
  assign rounds_cap = (rounds > 5'(MAX_ROUNDS)) ? 5'(MAX_ROUNDS) : rounds;

  logic [31:0] prev, back, tw, nw;
  logic [WW-1:0] ks_words;
  assign ks_words = WW'(({2'b0, rounds_cap} + 7'd1) << 2);
  assign prev = win[15];
  // window index of word i-kw: element 16-kw
  assign back = win[4'(5'd16 - kw)];

  always_comb begin
    tw = prev;
    if (off == 5'd0) begin
      tw = {sbox(prev[23:16]) ^ rcon, sbox(prev[15:8]), sbox(prev[7:0]),
            sbox(prev[31:24])};
    end else if ((kw > 5'd12 && off == 5'd12) || (kw > 5'd8 && off == 5'd8) ||
                 (kw > 5'd6 && off == 5'd4)) begin
      tw = {sbox(prev[31:24]), sbox(prev[23:16]), sbox(prev[15:8]), sbox(prev[7:0])};
    end
    // words below the key length come straight from the cipher key
    if (widx < WW'(kw)) begin
      nw = widx[0] ? cipher_key[widx[3:1]][31:0] : cipher_key[widx[3:1]][63:32];
    end else begin
      nw = back ^ tw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 8; k++) cipher_key[k] <= '0;
    end else if (cmd.load_key) begin
      cipher_key[key_index] <= key_word;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_start) begin
      widx <= '0;
      off  <= '0;
      rcon <= RCON_INIT;
      nr   <= RkW'(rounds_cap);
    end else if (cmd.exp_step) begin
      for (int k = 0; k < 15; k++) win[k] <= win[k+1];
      win[15] <= nw;
      widx <= widx + WW'(1);
      off  <= (off == kw - 5'd1) ? 5'd0 : off + 5'd1;
      if (widx >= WW'(kw) && off == 5'd0) rcon <= xt(rcon);
      if (widx[1:0] == 2'd3) begin
        rk_mem[widx[WW-1:2]] <= {rk_part, nw};
      end else begin
        rk_part <= {rk_part[63:0], nw};
      end
    end
  end

  // rounds
  logic [127:0] st;
  logic [RkW-1:0] rnd;
  logic [127:0] rk_q;
  logic [RkW-1:0] rd_addr;
  logic [127:0] sb, mx, nst;

  assign sts = '{exp_done: (widx == ks_words - WW'(1)),
                 rnd_done: (cmd.dec ? (rnd == RkW'(1)) : (rnd == nr - RkW'(1)))};

  always_comb begin
    if (cmd.blk_load) rd_addr = cmd.dec ? nr - RkW'(1) : RkW'(1);
    else rd_addr = cmd.dec ? rnd - RkW'(1) : rnd + RkW'(1);
  end

  // encrypt round: sub+shift, mix (skipped in the last round), addkey
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[127-8*i -: 8] = sbox(st[127-8*shift_src(4'(i)) -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      mx[127-32*c -: 32] = mix_col(sb[127-32*c -: 32], 1'b0);
    end
    nst = (cmd.rnd_last ? sb : mx) ^ rk_q;
  end

  // decrypt round: addkey, invmix, invshift, invsub; block load already
  // did addkey+invshift+invsub of the top round
  logic [127:0] dk, dm, dsr;
  always_comb begin
    dk = st ^ rk_q;
    for (int c = 0; c < 4; c++) dm[127-32*c -: 32] = mix_col(dk[127-32*c -: 32], 1'b1);
    for (int i = 0; i < 16; i++)
      dsr[127-8*i -: 8] = inv_sbox(dm[127-8*inv_shift_src(4'(i)) -: 8]);
  end

  logic [127:0] rk_first;
  always_ff @(posedge clk) begin
    rk_q <= rk_mem[rd_addr];
    rk_first <= rk_mem[cmd.dec ? nr : RkW'(0)];
  end

  // block load needs the first key in the same cycle: fetch it registered
  // beforehand, reading the address selected by the direction
  logic [127:0] blk_in;
  logic [127:0] blk;
  logic [127:0] dl;

  always_ff @(posedge clk) begin
    if (cmd.blk_cap) blk_in <= {block_hi, block_lo};
  end

  assign blk = blk_in ^ rk_first;
  always_comb begin
    for (int i = 0; i < 16; i++)
      dl[127-8*i -: 8] = inv_sbox(blk[127-8*inv_shift_src(4'(i)) -: 8]);
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_load) begin
      st  <= cmd.dec ? dl : blk;
      rnd <= cmd.dec ? nr - RkW'(1) : RkW'(1);
    end else if (cmd.rnd_step) begin
      if (cmd.rnd_last) begin
        st <= cmd.dec ? dk : nst;
      end else begin
        st <= cmd.dec ? dsr : nst;
      end
      rnd <= cmd.dec ? rnd - RkW'(1) : rnd + RkW'(1);
    end
  end

  assign result_hi = st[127:64];
  assign result_lo = st[63:0];
endmodule
`default_nettype wire

@@ rtl/core/aes_block_cipher_extended_keys_core.sv @@
// AES block engine with 16- to 64-byte keys: top level joining controller and datapath.
// Depends on aesx_pkg, aesx_ctrl, aesx_dp.
`default_nettype none
// One item at a time. A key-word load is written on accept; the core stays idle.
// A block goes from accept through block load and the rounds, one at a time on
// the single shared round unit, to the result; the first block after a key load
// or key_size write first runs the key schedule, one 32-bit word per cycle.
// The result holds on result_hi/result_lo while valid and stall are high.
module aes_block_cipher_extended_keys_core #(
  parameter int MAX_ROUNDS = aesx_pkg::MaxRoundsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  func,
  input  wire logic [2:0]  key_index,
  input  wire logic [63:0] key_word,
  input  wire logic [63:0] block_hi,
  input  wire logic [63:0] block_lo,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      result_hi,
  output logic [63:0]      result_lo
);
  import aesx_pkg::*;

  aesx_cmd_t cmd;
  aesx_sts_t sts;
  logic [2:0] key_size;

  always_ff @(posedge clk) begin
    if (rst) key_size <= '0;
    else if (cfg_we) key_size <= cfg_data;
  end

  aesx_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .func, .cfg_we,
    .out_valid, .out_stall, .cmd, .sts
  );

  aesx_dp #(.MAX_ROUNDS(MAX_ROUNDS)) u_dp (
    .clk, .rst, .cmd, .sts, .key_size_reg(key_size), .key_index, .key_word,
    .block_hi, .block_lo, .result_hi, .result_lo
  );
endmodule
`default_nettype wire
